// ===== sv/frqs_pkg.sv =====
// ----------------------------------------------------------------------------
// frqs_pkg: shared types and constants of the FIFO run queue scheduler
// Field widths, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package frqs_pkg;

   // Fixed field widths
   localparam int TASK_W   = 4;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Number of distinct task ids that a field can carry
   localparam int TASK_IDS = 1 << TASK_W;

   // Parameter defaults and reset values
   localparam int                MAX_TASKS_DEF = 16;
   localparam logic [TASK_W-1:0] IDLE_RESET    = '0;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_ENQUEUE  = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_SCHEDULE = 2'd2,
      REQ_NOP      = 2'd3
   } req_code_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK              = 3'd0,
      ST_ALREADY         = 3'd1,
      ST_NOT_QUEUED      = 3'd2,
      ST_EMPTY           = 3'd3,
      ST_NOT_PREEMPTIBLE = 3'd4
   } status_code_type;

endpackage

// ===== sv/frqs_if.sv =====
// ----------------------------------------------------------------------------
// frqs_if: request and response channels of the run queue scheduler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Request channel: one scheduler request per item
interface frqs_req_if import frqs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [TASK_W-1:0]   task_id;
   logic                current_running;
   logic                preempt_blocked;

   modport source (output valid, req_type, task_id, current_running,
                   preempt_blocked, input ready);
   modport sink   (input valid, req_type, task_id, current_running,
                   preempt_blocked, output ready);
endinterface

// Response channel: one result item per request
interface frqs_rsp_if import frqs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                switched;
   logic [TASK_W-1:0]   prev_task;
   logic [TASK_W-1:0]   next_task;
   logic [COUNT_W-1:0]  queue_count;

   modport source (output valid, status, switched, prev_task, next_task,
                   queue_count, input ready);
   modport sink   (input valid, status, switched, prev_task, next_task,
                   queue_count, output ready);
endinterface

// ===== sv/fifo_run_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// fifo_run_queue_scheduler_core: round-robin FIFO ready queue of task ids
// Doubly linked list in per-task link registers, with enqueue, remove and
// schedule requests and one result item per request.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while the response side does not
// stall. The request is captured in an input register, the queue state (head,
// tail, count, queued flags, link registers) is updated in a single pass from
// that register, and the result lands in an output register.
// Each link register file is read at one address and written at one address
// per request, which is what lets a request follow in the very next cycle.
// A full response side stalls the input register and then the request channel.
// The idle task id is to be written through csr_wr_en/csr_wr_data only while
// no request is in flight; the block itself does not enforce this. The current
// task follows it if it was the idle task.
// ----------------------------------------------------------------------------
module fifo_run_queue_scheduler_core import frqs_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   frqs_req_if.sink          req_bus,
   frqs_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [TASK_W-1:0] csr_wr_data
);

   // Storage only for ids that a task field can name
   localparam int DEPTH = (MAX_TASKS < TASK_IDS) ? MAX_TASKS : TASK_IDS;
   localparam int IDX_W = $clog2(DEPTH);

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [REQ_W-1:0]    s1_type_ff;
   logic [TASK_W-1:0]   s1_task_ff;
   logic                s1_run_ff;
   logic                s1_blk_ff;

   // Queue state
   logic [TASK_W-1:0]   next_link_ff [DEPTH];
   logic [TASK_W-1:0]   prev_link_ff [DEPTH];
   logic [DEPTH-1:0]    queued_flag_ff, queued_flag_in;
   logic [TASK_W-1:0]   head_ff, head_in;
   logic [TASK_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [TASK_W-1:0]   current_ff, current_in;
   logic [TASK_W-1:0]   idle_ff, idle_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_switched_ff;
   logic [TASK_W-1:0]   rsp_prev_ff;
   logic [TASK_W-1:0]   rsp_next_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // Single-pass results
   status_code_type     status;
   logic                switched;
   logic [TASK_W-1:0]   item_current;

   // Link file ports
   logic [TASK_W-1:0]   nl_rd_addr;
   logic [TASK_W-1:0]   nl_rd;
   logic [TASK_W-1:0]   pl_rd;
   logic                nl_we, pl_we;
   logic [TASK_W-1:0]   nl_wa, nl_wd, pl_wa, pl_wd;

   // Handshake
   logic                rsp_open;
   logic                s1_fire;
   logic                req_take;

   // Request decode
   logic                t_ok;
   logic [IDX_W-1:0]    t_idx;
   logic                t_queued;
   logic [IDX_W-1:0]    head_idx;
   logic [IDX_W-1:0]    cur_idx;
   logic                requeue;

   // Advance the input register whenever the result register can take an item
   assign rsp_open      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && rsp_open;
   assign req_bus.ready = !s1_valid_ff || rsp_open;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Decode the task of the held item
   assign t_ok     = 32'(s1_task_ff) < MAX_TASKS;
   assign t_idx    = s1_task_ff[IDX_W-1:0];
   assign t_queued = t_ok && queued_flag_ff[t_idx];
   assign head_idx = head_ff[IDX_W-1:0];
   assign cur_idx  = current_ff[IDX_W-1:0];

   // Put the current task back unless idle, not running, not storable, or queued other than at the head
   assign requeue = (current_ff != idle_ff) && s1_run_ff &&
                    (32'(current_ff) < MAX_TASKS) &&
                    (!queued_flag_ff[cur_idx] || current_ff == head_ff);

   // Read the link files at one address each
   assign nl_rd_addr = (req_code_type'(s1_type_ff) == REQ_SCHEDULE) ? head_ff : s1_task_ff;
   assign nl_rd      = next_link_ff[nl_rd_addr[IDX_W-1:0]];
   assign pl_rd      = prev_link_ff[t_idx];

   // Update queue state for the held item
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      entry_count_in = entry_count_ff;
      queued_flag_in = queued_flag_ff;
      item_current   = current_ff;
      status         = ST_OK;
      switched       = 1'b0;
      nl_we          = 1'b0;
      nl_wa          = '0;
      nl_wd          = '0;
      pl_we          = 1'b0;
      pl_wa          = '0;
      pl_wd          = '0;
      if (s1_fire) begin
         case (req_code_type'(s1_type_ff))
            REQ_ENQUEUE: begin
               if (!t_ok) begin
                  status = ST_NOT_QUEUED;
               end else if (t_queued) begin
                  status = ST_ALREADY;
               end else begin
                  queued_flag_in[t_idx] = 1'b1;
                  entry_count_in        = entry_count_ff + 1'b1;
                  tail_in               = s1_task_ff;
                  if (entry_count_ff == '0) begin
                     head_in = s1_task_ff;
                  end else begin
                     nl_we = 1'b1;
                     nl_wa = tail_ff;
                     nl_wd = s1_task_ff;
                     pl_we = 1'b1;
                     pl_wa = s1_task_ff;
                     pl_wd = tail_ff;
                  end
               end
            end
            REQ_REMOVE: begin
               if (!t_queued) begin
                  status = ST_NOT_QUEUED;
               end else begin
                  queued_flag_in[t_idx] = 1'b0;
                  if (entry_count_ff <= COUNT_W'(1)) begin
                     head_in        = '0;
                     tail_in        = '0;
                     entry_count_in = '0;
                  end else begin
                     entry_count_in = entry_count_ff - 1'b1;
                     // Bypass the task from its neighbors
                     if (s1_task_ff == head_ff) begin
                        head_in = nl_rd;
                     end else begin
                        nl_we = 1'b1;
                        nl_wa = pl_rd;
                        nl_wd = nl_rd;
                     end
                     if (s1_task_ff == tail_ff) begin
                        tail_in = pl_rd;
                     end else begin
                        pl_we = 1'b1;
                        pl_wa = nl_rd;
                        pl_wd = pl_rd;
                     end
                  end
               end
            end
            REQ_SCHEDULE: begin
               if (s1_blk_ff) begin
                  status = ST_NOT_PREEMPTIBLE;
               end else if (entry_count_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  // Pop the head, then requeue the current task at the tail
                  queued_flag_in[head_idx] = 1'b0;
                  if (requeue) begin
                     queued_flag_in[cur_idx] = 1'b1;
                  end
                  item_current = head_ff;
                  switched     = (head_ff != current_ff);
                  if (entry_count_ff == COUNT_W'(1)) begin
                     if (requeue) begin
                        head_in = current_ff;
                        tail_in = current_ff;
                     end else begin
                        head_in        = '0;
                        tail_in        = '0;
                        entry_count_in = '0;
                     end
                  end else begin
                     head_in = nl_rd;
                     if (requeue) begin
                        tail_in = current_ff;
                        nl_we   = 1'b1;
                        nl_wa   = tail_ff;
                        nl_wd   = current_ff;
                        pl_we   = 1'b1;
                        pl_wa   = current_ff;
                        pl_wd   = tail_ff;
                     end else begin
                        entry_count_in = entry_count_ff - 1'b1;
                     end
                  end
               end
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   // Let the current task follow an idle id rewrite
   always_comb begin
      idle_in    = idle_ff;
      current_in = item_current;
      if (csr_wr_en) begin
         idle_in = csr_wr_data;
         if (current_ff == idle_ff) begin
            current_in = csr_wr_data;
         end
      end
   end

   // Control and queue state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         queued_flag_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         entry_count_ff <= '0;
         current_ff     <= IDLE_RESET;
         idle_ff        <= IDLE_RESET;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         queued_flag_ff <= queued_flag_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         entry_count_ff <= entry_count_in;
         current_ff     <= current_in;
         idle_ff        <= idle_in;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req_bus.req_type;
         s1_task_ff <= req_bus.task_id;
         s1_run_ff  <= req_bus.current_running;
         s1_blk_ff  <= req_bus.preempt_blocked;
      end
   end

   // Write the link files
   always_ff @(posedge clock) begin
      if (nl_we) begin
         next_link_ff[nl_wa[IDX_W-1:0]] <= nl_wd;
      end
      if (pl_we) begin
         prev_link_ff[pl_wa[IDX_W-1:0]] <= pl_wd;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_status_ff   <= status;
         rsp_switched_ff <= switched;
         rsp_prev_ff     <= current_ff;
         rsp_next_ff     <= item_current;
         rsp_count_ff    <= entry_count_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.switched    = rsp_switched_ff;
   assign rsp_bus.prev_task   = rsp_prev_ff;
   assign rsp_bus.next_task   = rsp_next_ff;
   assign rsp_bus.queue_count = rsp_count_ff;

`ifndef ASSERT_OFF
   // Count never exceeds the storable tasks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= COUNT_W'(DEPTH))
      else $error("queue count above capacity");

   // Queued flags agree with the count
   a_flags_count: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_flag_ff) == 32'(entry_count_ff))
      else $error("queued flags disagree with queue count");

   // Empty queue parks head and tail at zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff == '0 |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with nonzero head or tail");

   // Head and tail of a non-empty queue are queued
   a_ends_queued: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff != '0 |->
         (queued_flag_ff[head_ff[IDX_W-1:0]] && queued_flag_ff[tail_ff[IDX_W-1:0]]))
      else $error("queue end not marked queued");

   // A switch is reported only with a good status and a new task
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switched_ff) |->
         (rsp_status_ff == ST_OK && rsp_prev_ff != rsp_next_ff))
      else $error("switch reported without a task change");
`endif

endmodule
